FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file for its concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, sampled on the rising clock edge and disabled in reset.
`define ALTE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication check, disabled in reset.
`define ALTE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/alte_pkg.sv
// Package with the shared types, codes and constants of the list engine.
package alte_pkg;

  localparam int unsigned CAPACITY_DEF = 128;

  localparam logic [2:0] KIND_APPEND  = 3'd0;
  localparam logic [2:0] KIND_INSERT  = 3'd1;
  localparam logic [2:0] KIND_SORTINS = 3'd2;
  localparam logic [2:0] KIND_DELETE  = 3'd3;
  localparam logic [2:0] KIND_KTH     = 3'd4;
  localparam logic [2:0] KIND_SORT    = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_BIN_RD,
    S_BIN_CHK,
    S_LIN_RD,
    S_LIN_CHK,
    S_UP_RD,
    S_UP_WR,
    S_PUT,
    S_DN_RD,
    S_DN_WR,
    S_KTH_RD,
    S_KTH_DONE,
    S_SO_OUTER,
    S_SO_RDJ,
    S_SO_CHK,
    S_SO_RDI,
    S_SO_WRI,
    S_SO_WRM,
    S_FINISH,
    S_OUT
  } alte_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic latch_in;     // capture input transaction
    logic rd_i;         // read memory at index i
    logic rd_im1;       // read memory at i-1
    logic rd_ip1;       // read memory at i+1
    logic rd_j;         // read memory at j
    logic rd_m;         // read memory at m
    logic rd_mid;       // read memory at binary midpoint
    logic wr_i_rd;      // write read data to index i
    logic wr_at_val;    // write input value at index at
    logic wr_i_tmp;     // write tmp2 to index i
    logic wr_m_tmp2;    // write tmp to index m
    logic hold_tmp;     // hold read data in tmp
    logic hold_tmp2;    // hold read data in tmp2
    logic hold_min;     // hold read data as current minimum, m <- j
    logic i_from_cnt;   // i <- count
    logic i_dec;
    logic i_inc;
    logic i_zero;
    logic at_from_i;
    logic at_from_cnt;
    logic at_from_pos;
    logic at_from_mid;
    logic j_from_i1;
    logic j_inc;
    logic m_from_i;
    logic bin_init;
    logic bin_lo;       // ub <- mid-1
    logic bin_hi;       // lb <- mid+1
    logic cnt_inc;
    logic cnt_dec;
    logic set_res;
    logic [1:0] res_status;
    logic res_idx_at;
    logic res_rd;
  } alte_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [2:0] kind;
    logic       mode;
    logic       full;
    logic       pos_gt_cnt;
    logic       pos_ge_cnt;
    logic       i_lt_cnt;
    logic       i_gt_at;
    logic       ip1_lt_cnt;
    logic       j_lt_cnt;
    logic       i1_lt_cnt;
    logic       rd_gt_val;
    logic       rd_eq_val;
    logic       rd_lt_min;
    logic       bin_live;
  } alte_sts_t;

endpackage

FILE: rtl/alte_ctrl.sv
// Controller state machine of the list engine.
module alte_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  alte_pkg::alte_sts_t  sts,
  output alte_pkg::alte_cmd_t  cmd
);

  alte_pkg::alte_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= alte_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      alte_pkg::S_IDLE: if (in_valid) state_nxt = alte_pkg::S_DISPATCH;
      alte_pkg::S_DISPATCH: begin
        unique case (sts.kind)
          alte_pkg::KIND_APPEND:
            state_nxt = sts.full ? alte_pkg::S_FINISH : alte_pkg::S_UP_RD;
          alte_pkg::KIND_INSERT:
            state_nxt = (sts.full || sts.pos_gt_cnt) ? alte_pkg::S_FINISH : alte_pkg::S_UP_RD;
          alte_pkg::KIND_SORTINS:
            state_nxt = sts.full ? alte_pkg::S_FINISH : alte_pkg::S_SCAN_RD;
          alte_pkg::KIND_DELETE:
            state_nxt = sts.mode ? alte_pkg::S_BIN_RD : alte_pkg::S_LIN_RD;
          alte_pkg::KIND_KTH:
            state_nxt = sts.pos_ge_cnt ? alte_pkg::S_FINISH : alte_pkg::S_KTH_RD;
          alte_pkg::KIND_SORT: state_nxt = alte_pkg::S_SO_OUTER;
          default: state_nxt = alte_pkg::S_FINISH;
        endcase
      end
      alte_pkg::S_SCAN_RD:
        state_nxt = sts.i_lt_cnt ? alte_pkg::S_SCAN_CHK : alte_pkg::S_UP_RD;
      alte_pkg::S_SCAN_CHK:
        state_nxt = sts.rd_gt_val ? alte_pkg::S_UP_RD : alte_pkg::S_SCAN_RD;
      alte_pkg::S_BIN_RD:
        state_nxt = sts.bin_live ? alte_pkg::S_BIN_CHK : alte_pkg::S_FINISH;
      alte_pkg::S_BIN_CHK:
        state_nxt = sts.rd_eq_val ? alte_pkg::S_DN_RD : alte_pkg::S_BIN_RD;
      alte_pkg::S_LIN_RD:
        state_nxt = sts.i_lt_cnt ? alte_pkg::S_LIN_CHK : alte_pkg::S_FINISH;
      alte_pkg::S_LIN_CHK:
        state_nxt = sts.rd_eq_val ? alte_pkg::S_DN_RD : alte_pkg::S_LIN_RD;
      alte_pkg::S_UP_RD: state_nxt = sts.i_gt_at ? alte_pkg::S_UP_WR : alte_pkg::S_PUT;
      alte_pkg::S_UP_WR: state_nxt = alte_pkg::S_UP_RD;
      alte_pkg::S_PUT:   state_nxt = alte_pkg::S_FINISH;
      alte_pkg::S_DN_RD: state_nxt = sts.ip1_lt_cnt ? alte_pkg::S_DN_WR : alte_pkg::S_FINISH;
      alte_pkg::S_DN_WR: state_nxt = alte_pkg::S_DN_RD;
      alte_pkg::S_KTH_RD:   state_nxt = alte_pkg::S_KTH_DONE;
      alte_pkg::S_KTH_DONE: state_nxt = alte_pkg::S_OUT;
      alte_pkg::S_SO_OUTER: state_nxt = sts.i1_lt_cnt ? alte_pkg::S_SO_RDJ : alte_pkg::S_FINISH;
      alte_pkg::S_SO_RDJ:   state_nxt = sts.j_lt_cnt ? alte_pkg::S_SO_CHK : alte_pkg::S_SO_RDI;
      alte_pkg::S_SO_CHK:   state_nxt = alte_pkg::S_SO_RDJ;
      alte_pkg::S_SO_RDI:   state_nxt = alte_pkg::S_SO_WRI;
      alte_pkg::S_SO_WRI:   state_nxt = alte_pkg::S_SO_WRM;
      alte_pkg::S_SO_WRM:   state_nxt = alte_pkg::S_SO_OUTER;
      alte_pkg::S_FINISH:   state_nxt = alte_pkg::S_OUT;
      alte_pkg::S_OUT:      if (!out_stall) state_nxt = alte_pkg::S_IDLE;
      default:              state_nxt = alte_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      alte_pkg::S_IDLE: begin
        in_stall     = 1'b0;
        cmd.latch_in = in_valid;
      end
      alte_pkg::S_DISPATCH: begin
        cmd.set_res = 1'b1;
        unique case (sts.kind)
          alte_pkg::KIND_APPEND: begin
            if (sts.full) cmd.res_status = alte_pkg::ST_FULL;
            cmd.at_from_cnt = 1'b1;
            cmd.i_from_cnt  = 1'b1;
          end
          alte_pkg::KIND_INSERT: begin
            if (sts.full) cmd.res_status = alte_pkg::ST_FULL;
            else if (sts.pos_gt_cnt) cmd.res_status = alte_pkg::ST_RANGE;
            cmd.at_from_pos = 1'b1;
            cmd.i_from_cnt  = 1'b1;
          end
          alte_pkg::KIND_SORTINS: begin
            if (sts.full) cmd.res_status = alte_pkg::ST_FULL;
            cmd.i_zero = 1'b1;
          end
          alte_pkg::KIND_DELETE: begin
            cmd.res_status = alte_pkg::ST_NOTFOUND;
            cmd.bin_init   = 1'b1;
            cmd.i_zero     = 1'b1;
          end
          alte_pkg::KIND_KTH: begin
            if (sts.pos_ge_cnt) cmd.res_status = alte_pkg::ST_RANGE;
            cmd.at_from_pos = 1'b1;
          end
          alte_pkg::KIND_SORT: cmd.i_zero = 1'b1;
          default: ;
        endcase
      end
      alte_pkg::S_SCAN_RD: begin
        cmd.rd_i = 1'b1;
        if (!sts.i_lt_cnt) begin
          cmd.at_from_cnt = 1'b1;
          cmd.i_from_cnt  = 1'b1;
        end
      end
      alte_pkg::S_SCAN_CHK: begin
        if (sts.rd_gt_val) begin
          cmd.at_from_i  = 1'b1;
          cmd.i_from_cnt = 1'b1;
        end else cmd.i_inc = 1'b1;
      end
      alte_pkg::S_BIN_RD: cmd.rd_mid = 1'b1;
      alte_pkg::S_BIN_CHK: begin
        if (sts.rd_eq_val) begin
          cmd.at_from_mid = 1'b1;
          cmd.set_res     = 1'b1;
          cmd.res_status  = alte_pkg::ST_OK;
          cmd.res_idx_at  = 1'b1;
        end else if (sts.rd_gt_val) cmd.bin_lo = 1'b1;
        else cmd.bin_hi = 1'b1;
      end
      alte_pkg::S_LIN_RD: cmd.rd_i = 1'b1;
      alte_pkg::S_LIN_CHK: begin
        if (sts.rd_eq_val) begin
          cmd.at_from_i  = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = alte_pkg::ST_OK;
          cmd.res_idx_at = 1'b1;
        end else cmd.i_inc = 1'b1;
      end
      alte_pkg::S_UP_RD: begin
        cmd.rd_im1 = 1'b1;
        if (!sts.i_gt_at) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = alte_pkg::ST_OK;
          cmd.res_idx_at = 1'b1;
        end
      end
      alte_pkg::S_UP_WR: begin
        cmd.wr_i_rd = 1'b1;
        cmd.i_dec   = 1'b1;
      end
      alte_pkg::S_PUT: begin
        cmd.wr_at_val = 1'b1;
        cmd.cnt_inc   = 1'b1;
      end
      alte_pkg::S_DN_RD: begin
        cmd.rd_ip1 = 1'b1;
        if (!sts.ip1_lt_cnt) cmd.cnt_dec = 1'b1;
      end
      alte_pkg::S_DN_WR: begin
        cmd.wr_i_rd = 1'b1;
        cmd.i_inc   = 1'b1;
      end
      // The default read address is at, which holds the requested position.
      alte_pkg::S_KTH_RD: ;
      alte_pkg::S_KTH_DONE: begin
        cmd.set_res    = 1'b1;
        cmd.res_status = alte_pkg::ST_OK;
        cmd.res_idx_at = 1'b1;
        cmd.res_rd     = 1'b1;
      end
      alte_pkg::S_SO_OUTER: begin
        cmd.j_from_i1 = 1'b1;
        cmd.m_from_i  = 1'b1;
        cmd.rd_i      = 1'b1;
      end
      alte_pkg::S_SO_RDJ: begin
        if (sts.j_lt_cnt) cmd.rd_j = 1'b1;
        else cmd.rd_m = 1'b1;
      end
      alte_pkg::S_SO_CHK: begin
        cmd.hold_min = sts.rd_lt_min;
        cmd.j_inc    = 1'b1;
      end
      alte_pkg::S_SO_RDI: begin
        cmd.hold_tmp2 = 1'b1;
        cmd.rd_i      = 1'b1;
      end
      alte_pkg::S_SO_WRI: begin
        cmd.hold_tmp = 1'b1;
        cmd.wr_i_tmp = 1'b1;
      end
      alte_pkg::S_SO_WRM: begin
        cmd.wr_m_tmp2 = 1'b1;
        cmd.i_inc     = 1'b1;
      end
      alte_pkg::S_FINISH: ;
      alte_pkg::S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: rtl/alte_dp.sv
// Datapath of the list engine: element memory, indices, count and result registers.
module alte_dp #(
  parameter int unsigned CAPACITY = alte_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_write,
  input  logic                cfg_data,
  input  logic [2:0]          in_kind,
  input  logic [7:0]          in_position,
  input  logic signed [31:0]  in_value,
  input  alte_pkg::alte_cmd_t cmd,
  output alte_pkg::alte_sts_t sts,
  output logic [1:0]          out_status,
  output logic [6:0]          out_found_index,
  output logic signed [31:0]  out_read_value,
  output logic [7:0]          out_count
);

  localparam int unsigned AW = $clog2(CAPACITY);
  // At least nine bits so that the position and the output fields always fit.
  localparam int unsigned CW = ($clog2(CAPACITY + 1) + 1 > 9) ? $clog2(CAPACITY + 1) + 1 : 9;

  logic [31:0] mem [CAPACITY];

  logic              mode_r;
  logic [2:0]        kind_r;
  logic [CW-1:0]     pos_r;
  logic signed [31:0] val_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     i_r, j_r, m_r, at_r;
  logic signed [CW:0] lb_r, ub_r;
  logic signed [31:0] rd_r, min_r, tmp_r, tmp2_r;
  logic [1:0]        st_r;
  logic [CW-1:0]     idx_r;
  logic signed [31:0] rv_r;
  logic              min_first_r;

  logic [CW-1:0]     mid;
  logic [CW-1:0]     raddr;
  logic              rd_en;
  logic signed [CW:0] mid_s;

  assign mid_s = lb_r + ((ub_r - lb_r) >>> 1);
  assign mid   = mid_s[CW-1:0];

  always_comb begin
    rd_en = 1'b1;
    raddr = i_r;
    if (cmd.rd_im1)      raddr = i_r - 1'b1;
    else if (cmd.rd_ip1) raddr = i_r + 1'b1;
    else if (cmd.rd_j)   raddr = j_r;
    else if (cmd.rd_m)   raddr = m_r;
    else if (cmd.rd_mid) raddr = mid;
    else if (cmd.rd_i)   raddr = i_r;
    else                 raddr = at_r;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_r <= mem[raddr[AW-1:0]];
    if (cmd.wr_i_rd)        mem[i_r[AW-1:0]]  <= rd_r;
    else if (cmd.wr_at_val) mem[at_r[AW-1:0]] <= val_r;
    else if (cmd.wr_i_tmp)  mem[i_r[AW-1:0]]  <= tmp2_r;
    else if (cmd.wr_m_tmp2) mem[m_r[AW-1:0]]  <= tmp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
      cnt_r  <= '0;
    end else begin
      if (cfg_write) mode_r <= cfg_data;
      if (cmd.cnt_inc) cnt_r <= cnt_r + 1'b1;
      else if (cmd.cnt_dec) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r <= in_kind;
      pos_r  <= CW'(in_position);
      val_r  <= in_value;
    end
    if (cmd.i_from_cnt)       i_r <= cnt_r;
    else if (cmd.i_zero)      i_r <= '0;
    else if (cmd.i_dec)       i_r <= i_r - 1'b1;
    else if (cmd.i_inc)       i_r <= i_r + 1'b1;
    else if (cmd.at_from_mid) i_r <= mid;
    if (cmd.at_from_cnt)      at_r <= cnt_r;
    else if (cmd.at_from_pos) at_r <= pos_r;
    else if (cmd.at_from_i)   at_r <= i_r;
    else if (cmd.at_from_mid) at_r <= mid;
    if (cmd.j_from_i1) j_r <= i_r + 1'b1;
    else if (cmd.j_inc) j_r <= j_r + 1'b1;
    if (cmd.m_from_i) m_r <= i_r;
    else if (cmd.hold_min) m_r <= j_r;
    // The first read of element j arrives while element i is still in rd_r,
    // so that is when the running minimum starts.
    if (cmd.m_from_i) min_first_r <= 1'b1;
    else if (cmd.rd_j) min_first_r <= 1'b0;
    if ((cmd.rd_j && min_first_r) || cmd.hold_min) min_r <= rd_r;
    if (cmd.hold_tmp)  tmp_r  <= rd_r;
    if (cmd.hold_tmp2) tmp2_r <= rd_r;
    if (cmd.bin_init) begin
      lb_r <= '0;
      ub_r <= $signed({1'b0, cnt_r}) - 2'sd1;
    end else if (cmd.bin_lo) ub_r <= mid_s - 2'sd1;
    else if (cmd.bin_hi)     lb_r <= mid_s + 2'sd1;
    if (cmd.set_res) begin
      st_r <= cmd.res_status;
      if (cmd.at_from_mid)     idx_r <= mid;
      else if (cmd.at_from_i)  idx_r <= i_r;
      else if (cmd.res_idx_at) idx_r <= at_r;
      else                     idx_r <= '0;
      rv_r <= cmd.res_rd ? rd_r : 32'sd0;
    end
  end

  assign sts.kind       = kind_r;
  assign sts.mode       = mode_r;
  assign sts.full       = cnt_r >= CW'(CAPACITY);
  assign sts.pos_gt_cnt = pos_r > cnt_r;
  assign sts.pos_ge_cnt = pos_r >= cnt_r;
  assign sts.i_lt_cnt   = i_r < cnt_r;
  assign sts.i_gt_at    = i_r > at_r;
  assign sts.ip1_lt_cnt = (i_r + 1'b1) < cnt_r;
  assign sts.j_lt_cnt   = j_r < cnt_r;
  assign sts.i1_lt_cnt  = (i_r + 1'b1) < cnt_r;
  assign sts.rd_gt_val  = rd_r > val_r;
  assign sts.rd_eq_val  = rd_r == val_r;
  assign sts.rd_lt_min  = rd_r < min_r;
  assign sts.bin_live   = lb_r <= ub_r;

  assign out_status      = st_r;
  assign out_found_index = idx_r[6:0];
  assign out_read_value  = rv_r;
  assign out_count       = cnt_r[7:0];

endmodule

FILE: rtl/array_list_table_engine_unit.sv
// Top level of the list engine: a packed list of signed words with search, shift and sort.
//
// The block keeps up to CAPACITY signed 32-bit elements in a memory with one read and
// one write port plus an element count, and performs one operation per input
// transaction, answering with exactly one result transaction. Items are handled one at
// a time; the time per item is set by the memory, which gives one read and one write
// per cycle. Append and insert shift the entries from the index up by one, sorted
// insert first scans for its place, delete probes (binary or linear) and then shifts
// the entries above down, read-kth reads one entry and sort is a selection sort. The
// memory is not cleared after reset; values read at or above the count are never used.
// The ordered_mode register selects binary (1) or linear (0) search for delete; the
// user must write it only while the block is idle, which the block does not enforce.
`include "assert_macros.svh"
module array_list_table_engine_unit #(
  parameter int unsigned CAPACITY = alte_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic [7:0]         in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [6:0]         out_found_index,
  output logic signed [31:0] out_read_value,
  output logic [7:0]         out_count
);

  alte_pkg::alte_cmd_t cmd;
  alte_pkg::alte_sts_t sts;

  alte_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  alte_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk, .rst_n, .cfg_write, .cfg_data, .in_kind, .in_position, .in_value,
    .cmd, .sts, .out_status, .out_found_index, .out_read_value, .out_count
  );

  // The engine never takes a new transaction while a result is pending.
  `ALTE_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, in_stall)
  // An accepted transaction is followed by a busy cycle.
  `ALTE_ASSERT_NXT(a_busy_after, clk, rst_n, in_valid && !in_stall, in_stall && !out_valid)
  // A stalled result keeps its count.
  `ALTE_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, $stable(out_count))

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the list engine: directed table, random traffic and a fill to capacity.
module testbench;

  // One expected result, as predicted or as typed into the directed table.
  typedef struct {
    logic [1:0]         status;
    logic [6:0]         found_index;
    logic signed [31:0] read_value;
    logic [7:0]         count;
  } list_result_t;

  // One row of the directed table; chk marks rows whose result is typed in.
  typedef struct {
    logic [2:0]         kind;
    logic [7:0]         position;
    logic signed [31:0] value;
    bit                 chk;
    list_result_t       res;
  } op_row_t;

  localparam int unsigned DEPTH = alte_pkg::CAPACITY_DEF;
  localparam int NUM_RANDOM = 520;

  logic               clk;
  logic               rst_n;
  logic               cfg_write;
  logic               cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_kind;
  logic [7:0]         in_position;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic [6:0]         out_found_index;
  logic signed [31:0] out_read_value;
  logic [7:0]         out_count;

  array_list_table_engine_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_read_value  (out_read_value),
    .out_count       (out_count)
  );

  // The predictor's own copy of the list, its length and the search mode.
  logic signed [31:0] shadow_list [DEPTH];
  int                 shadow_len;
  bit                 shadow_ordered;

  // Results still owed by the block, oldest first.
  list_result_t pending_results [$];
  int           mismatches;

  // Typed expectation that rides along with the transaction on offer.
  bit           row_typed;
  list_result_t row_result;

  // Both sides idle only while this is set; cleared for stretches of full rate.
  bit idling_on;
  // Pulsed by the sender to make the receiver hold off for a long stretch.
  bit long_hold_req;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    mismatches++;
  endtask

  // Inserts v at index at, moving the entries at and above up by one.
  function automatic void list_put(input int at, input logic signed [31:0] v);
    for (int i = shadow_len; i > at; i--) shadow_list[i] = shadow_list[i - 1];
    shadow_list[at] = v;
    shadow_len++;
  endfunction

  // Works out the result of one operation and applies it to the shadow list.
  function automatic list_result_t list_apply(input logic [2:0] kind, input logic [7:0] pos,
                                              input logic signed [31:0] v);
    list_result_t r;
    int at;
    int lb;
    int ub;
    int mid;
    int m;
    bit hit;
    bit full;
    logic signed [31:0] t;
    r = '{status: alte_pkg::ST_OK, found_index: '0, read_value: '0, count: '0};
    full = shadow_len >= DEPTH;
    case (kind)
      alte_pkg::KIND_APPEND: begin
        if (full) begin
          r.status = alte_pkg::ST_FULL;
        end else begin
          r.found_index = shadow_len[6:0];
          list_put(shadow_len, v);
        end
      end
      alte_pkg::KIND_INSERT: begin
        if (full) begin
          r.status = alte_pkg::ST_FULL;
        end else if (pos > shadow_len) begin
          r.status = alte_pkg::ST_RANGE;
        end else begin
          r.found_index = pos[6:0];
          list_put(pos, v);
        end
      end
      alte_pkg::KIND_SORTINS: begin
        if (full) begin
          r.status = alte_pkg::ST_FULL;
        end else begin
          at = shadow_len;
          for (int i = 0; i < shadow_len; i++) begin
            if (shadow_list[i] > v) begin
              at = i;
              break;
            end
          end
          r.found_index = at[6:0];
          list_put(at, v);
        end
      end
      alte_pkg::KIND_DELETE: begin
        hit = 1'b0;
        at = 0;
        if (shadow_ordered) begin
          lb = 0;
          ub = shadow_len - 1;
          while (lb <= ub && !hit) begin
            mid = lb + (ub - lb) / 2;
            if (shadow_list[mid] == v) begin
              hit = 1'b1;
              at = mid;
            end else if (shadow_list[mid] > v) begin
              ub = mid - 1;
            end else begin
              lb = mid + 1;
            end
          end
        end else begin
          for (int i = 0; i < shadow_len && !hit; i++) begin
            if (shadow_list[i] == v) begin
              hit = 1'b1;
              at = i;
            end
          end
        end
        if (!hit) begin
          r.status = alte_pkg::ST_NOTFOUND;
        end else begin
          r.found_index = at[6:0];
          for (int i = at; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_len--;
        end
      end
      alte_pkg::KIND_KTH: begin
        if (pos >= shadow_len) begin
          r.status = alte_pkg::ST_RANGE;
        end else begin
          r.found_index = pos[6:0];
          r.read_value = shadow_list[pos];
        end
      end
      alte_pkg::KIND_SORT: begin
        // Selection sort, swapping even when the minimum is already in place.
        for (int i = 0; i + 1 < shadow_len; i++) begin
          m = i;
          for (int j = i + 1; j < shadow_len; j++) begin
            if (shadow_list[j] < shadow_list[m]) m = j;
          end
          t = shadow_list[i];
          shadow_list[i] = shadow_list[m];
          shadow_list[m] = t;
        end
      end
      default: begin
      end
    endcase
    r.count = shadow_len[7:0];
    return r;
  endfunction

  // Both handshakes are observed on the rising edge, before the block's own
  // registers move, so every decision here sees the values from before the edge.
  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = list_apply(in_kind, in_position, in_value);
        if (row_typed) want = row_result;
        pending_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = '{status: out_status, found_index: out_found_index,
                read_value: out_read_value, count: out_count};
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.found_index !== want.found_index)
            report_mismatch("found_index", got.found_index, want.found_index);
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
          if (got.count !== want.count)
            report_mismatch("count", got.count, want.count);
        end
      end
    end
  end

  // Random gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one transaction and holds it until the block takes it.
  task automatic send_op(input logic [2:0] kind, input logic [7:0] pos,
                         input logic signed [31:0] v, input bit typed = 1'b0,
                         input list_result_t res = '{default: '0});
    int gap;
    in_kind = kind;
    in_position = pos;
    in_value = v;
    row_typed = typed;
    row_result = res;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Waits for every owed result, then a little longer, before touching config.
  task automatic write_mode(input bit mode);
    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (8) @(negedge clk);
    cfg_data = mode;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
    shadow_ordered = mode;
  endtask

  // Picks a value for a new element: mostly from a small pool so deletes hit.
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $signed($urandom_range(0, 40)) - 20;
    if (r == 6) return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
    return $signed($urandom());
  endfunction

  // Sends one random operation, steering the list length to stay moderate.
  task automatic send_random_op();
    int r;
    logic [2:0] kind;
    logic [7:0] pos;
    logic signed [31:0] v;
    r = $urandom_range(0, 199);
    v = pick_value();
    pos = (shadow_len > 0) ? 8'($urandom_range(0, shadow_len)) : 8'd0;
    if (r < 4) pos = 8'($urandom_range(0, 255));
    if (r < 30) begin
      kind = (shadow_len > 40) ? alte_pkg::KIND_DELETE : alte_pkg::KIND_APPEND;
    end else if (r < 60) begin
      kind = (shadow_len > 40) ? alte_pkg::KIND_DELETE : alte_pkg::KIND_INSERT;
    end else if (r < 95) begin
      kind = (shadow_len > 40) ? alte_pkg::KIND_DELETE : alte_pkg::KIND_SORTINS;
    end else if (r < 150) begin
      kind = alte_pkg::KIND_DELETE;
      // Most deletes target a value that is really in the list.
      if (shadow_len > 0 && $urandom_range(0, 3) != 0)
        v = shadow_list[$urandom_range(0, shadow_len - 1)];
    end else if (r < 192) begin
      kind = alte_pkg::KIND_KTH;
    end else if (r < 196) begin
      kind = alte_pkg::KIND_SORT;
    end else begin
      kind = 3'($urandom_range(6, 7));
    end
    send_op(kind, pos, v);
  endtask

  // The receiver stalls at random, and once holds off long enough that the
  // block, busy with one transaction, has to stall its input.
  initial begin
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
      end else if (!idling_on || $urandom_range(0, 99) < 70) begin
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 40)) @(negedge clk);
      end
    end
  end

  initial begin
    op_row_t rows [$];
    rst_n = 1'b0;
    cfg_write = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    in_kind = '0;
    in_position = '0;
    in_value = '0;
    row_typed = 1'b0;
    row_result = '{default: '0};
    idling_on = 1'b1;
    long_hold_req = 1'b0;
    mismatches = 0;
    shadow_len = 0;
    shadow_ordered = 1'b1;
    for (int i = 0; i < DEPTH; i++) shadow_list[i] = '0;

    // Directed table; typed results cover the empty list and the extremes.
    rows = '{
      '{alte_pkg::KIND_KTH,     8'd0,   32'sd0,        1,
        '{alte_pkg::ST_RANGE,    7'd0, 32'sd0, 8'd0}},
      '{alte_pkg::KIND_DELETE,  8'd0,   32'sd5,        1,
        '{alte_pkg::ST_NOTFOUND, 7'd0, 32'sd0, 8'd0}},
      '{alte_pkg::KIND_INSERT,  8'd1,   32'sd9,        1,
        '{alte_pkg::ST_RANGE,    7'd0, 32'sd0, 8'd0}},
      '{alte_pkg::KIND_SORT,    8'd0,   32'sd0,        1,
        '{alte_pkg::ST_OK,       7'd0, 32'sd0, 8'd0}},
      '{alte_pkg::KIND_APPEND,  8'd0,   32'sh7fffffff, 1,
        '{alte_pkg::ST_OK,       7'd0, 32'sd0, 8'd1}},
      '{alte_pkg::KIND_APPEND,  8'd255, 32'sh80000000, 1,
        '{alte_pkg::ST_OK,       7'd1, 32'sd0, 8'd2}},
      '{alte_pkg::KIND_KTH,     8'd1,   32'sd0,        1,
        '{alte_pkg::ST_OK,       7'd1, 32'sh80000000, 8'd2}},
      '{alte_pkg::KIND_KTH,     8'd255, 32'sd0,        1,
        '{alte_pkg::ST_RANGE,    7'd0, 32'sd0, 8'd2}},
      '{alte_pkg::KIND_SORTINS, 8'd0,   32'sd0,        0, '{default: '0}},
      '{alte_pkg::KIND_SORTINS, 8'd0,   32'sh7fffffff, 0, '{default: '0}},
      '{alte_pkg::KIND_INSERT,  8'd0,   -32'sd5,       0, '{default: '0}},
      '{alte_pkg::KIND_INSERT,  8'd5,   32'sd3,        0, '{default: '0}},
      '{alte_pkg::KIND_INSERT,  8'd7,   32'sd3,        0, '{default: '0}},
      '{alte_pkg::KIND_DELETE,  8'd0,   32'sd3,        0, '{default: '0}},
      '{alte_pkg::KIND_SORT,    8'd0,   32'sd0,        0, '{default: '0}},
      '{alte_pkg::KIND_KTH,     8'd0,   32'sd0,        0, '{default: '0}},
      '{alte_pkg::KIND_DELETE,  8'd0,   32'sd0,        0, '{default: '0}},
      '{alte_pkg::KIND_DELETE,  8'd0,   32'sd12345,    0, '{default: '0}},
      '{alte_pkg::KIND_SORTINS, 8'd0,   32'sh80000000, 0, '{default: '0}},
      '{3'd6,                   8'd3,   32'sd1,        0, '{default: '0}},
      '{3'd7,                   8'd128, -32'sd1,       0, '{default: '0}},
      '{alte_pkg::KIND_KTH,     8'd128, 32'sd0,        0, '{default: '0}}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) send_op(rows[i].kind, rows[i].position, rows[i].value,
                              rows[i].chk, rows[i].res);

    // Linear search mode, with the long receiver hold-off while the sender waits on the stalled input.
    write_mode(1'b0);
    long_hold_req = 1'b1;
    for (int n = 0; n < NUM_RANDOM / 4; n++) send_random_op();

    // Fill the list to capacity, poke the full case, then drain part of it.
    write_mode(1'b1);
    idling_on = 1'b0;
    while (shadow_len < DEPTH) send_op(alte_pkg::KIND_APPEND, 8'd0, pick_value());
    send_op(alte_pkg::KIND_APPEND, 8'd0, 32'sd1);
    send_op(alte_pkg::KIND_INSERT, 8'd128, 32'sd1);
    send_op(alte_pkg::KIND_SORTINS, 8'd0, 32'sd1);
    send_op(alte_pkg::KIND_KTH, 8'd127, 32'sd0);
    send_op(alte_pkg::KIND_KTH, 8'd128, 32'sd0);
    send_op(alte_pkg::KIND_SORT, 8'd0, 32'sd0);
    send_op(alte_pkg::KIND_DELETE, 8'd0, shadow_list[DEPTH - 1]);
    send_op(alte_pkg::KIND_INSERT, 8'd127, 32'sd7);
    idling_on = 1'b1;
    while (shadow_len > 20)
      send_op(alte_pkg::KIND_DELETE, 8'd0, shadow_list[$urandom_range(0, shadow_len - 1)]);

    // Binary search mode, sorting first so the probes find their targets.
    send_op(alte_pkg::KIND_SORT, 8'd0, 32'sd0);
    for (int n = 0; n < NUM_RANDOM / 4; n++) send_random_op();

    // The sender pauses here until every owed result has come back.
    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk);
    for (int n = 0; n < NUM_RANDOM / 4; n++) send_random_op();

    write_mode(1'b0);
    for (int n = 0; n < NUM_RANDOM / 4; n++) send_random_op();
    write_mode(1'b1);
    for (int n = 0; n < 20; n++) send_random_op();

    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #400000000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/alte_pkg.sv
rtl/alte_ctrl.sv
rtl/alte_dp.sv
rtl/array_list_table_engine_unit.sv
dv/testbench.sv
